/* design/prfs_pkg.sv */
// Shared types and constants of the power rail fault retry supervisor.
package prfs_pkg;

  localparam int unsigned CH_W    = 4;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned RETRY_W = 4;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd2;

  localparam logic [15:0] ENABLE_MASK_RST = 16'd8159;
  localparam logic [15:0] CLEAR_DELAY_RST = 16'd5;
  localparam logic [3:0]  RETRY_LIMIT_RST = 4'd5;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 3'd0,
    EV_DETECTED = 3'd1,
    EV_CLEARED  = 3'd2,
    EV_RETRY    = 3'd3,
    EV_DISABLED = 3'd4
  } prfs_event_e;

  // Per-channel entry kept in the state memory
  typedef struct packed {
    logic               active;
    logic [RETRY_W-1:0] retries;
    logic [TICK_W-1:0]  last_time;
  } prfs_entry_t;

endpackage

/* design/prfs_if.sv */
// Channel interfaces: poll input, result output and configuration write.
interface prfs_poll_if;
  logic                       valid;
  logic                       ready;
  logic [prfs_pkg::CH_W-1:0]   channel;
  logic                       fault_asserted;
  logic [prfs_pkg::TICK_W-1:0] now_ticks;

  modport source (output valid, channel, fault_asserted, now_ticks, input ready);
  modport sink   (input valid, channel, fault_asserted, now_ticks, output ready);
endinterface

interface prfs_res_if;
  logic                         valid;
  logic                         ready;
  logic [prfs_pkg::CH_W-1:0]     channel_out;
  logic [prfs_pkg::EVENT_W-1:0]  event_res;
  logic [prfs_pkg::RETRY_W-1:0]  retry_number;
  logic                         log_valid;
  logic [prfs_pkg::SLOT_W-1:0]   log_slot;

  modport source (output valid, channel_out, event_res, retry_number, log_valid, log_slot,
                  input ready);
  modport sink   (input valid, channel_out, event_res, retry_number, log_valid, log_slot,
                  output ready);
endinterface

interface prfs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [prfs_pkg::CFG_IDX_W-1:0]    index;
  logic [prfs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/power_rail_fault_retry_supervisor.sv */
// Top level of the power rail fault retry supervisor.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------------
//   poll_if  | in  | valid / ready | channel, fault_asserted, now_ticks
//   res_if   | out | valid / ready | channel_out, event_res, retry_number,
//            |     |               | log_valid, log_slot
//   cfg_if   | in  | valid / ready | index, data (ready is always high)
//
// One poll per cycle sustained. A poll is transferred in and its channel entry is read
// from the state RAM; in the update stage the entry is updated and written back, and
// the result is loaded into the output register.
// A write back to the entry read by the next poll in the same cycle is forwarded.
// Reset clears per-entry valid flops at once, so no clearing pass is needed; an entry
// not yet written reads as all zero. A stalled result holds the update stage, and the
// poll channel then stalls too.
module power_rail_fault_retry_supervisor #(
  parameter int unsigned CHANNELS  = 16,
  parameter int unsigned LOG_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  prfs_poll_if.sink  poll_if,
  prfs_res_if.source res_if,
  prfs_cfg_if.sink   cfg_if
);
  import prfs_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SW = (LOG_SLOTS > 1) ? $clog2(LOG_SLOTS) : 1;
  localparam int unsigned EW = $bits(prfs_entry_t);
  localparam logic [SW-1:0] SLOT_LAST = SW'(LOG_SLOTS - 1);

  // Configuration registers
  logic [15:0] enable_mask_q;
  logic [15:0] clear_delay_q;
  logic [3:0]  retry_limit_q;

  // Pipeline control
  logic poll_xfer, s1_adv, s1_valid_q, out_valid_q;

  // Update stage item
  logic [CH_W-1:0]   s1_channel_q;
  logic              s1_fault_q;
  logic [TICK_W-1:0] s1_now_q;
  logic              s1_in_range_q;
  logic [AW-1:0]     s1_addr_q;
  logic              s1_entry_vld_q;
  logic              fwd_hit_q;
  prfs_entry_t       fwd_entry_q;

  // Per-entry valid flags and log ring pointer
  logic [CHANNELS-1:0] entry_vld_q, entry_vld_d;
  logic [SW-1:0]       next_slot_q, next_slot_d;

  logic [AW-1:0]        poll_addr;
  logic                 poll_in_range;
  logic [EW-1:0]        ram_rdata;
  prfs_entry_t          cur_entry, new_entry;
  prfs_event_e          ev;
  logic [SW+SLOT_W-1:0] slot_ext;
  logic                 log_vld;
  logic [TICK_W-1:0]    elapsed;
  logic                 en_bit;

  // Output register
  logic [CH_W-1:0]    out_channel_q;
  prfs_event_e        out_event_q;
  logic [RETRY_W-1:0] out_retry_q;
  logic               out_log_vld_q;
  logic [SLOT_W-1:0]  out_slot_q;

  // Handshakes
  assign s1_adv        = s1_valid_q && (!out_valid_q || res_if.ready);
  assign poll_if.ready = !s1_valid_q || s1_adv;
  assign poll_xfer     = poll_if.valid && poll_if.ready;
  assign cfg_if.ready  = 1'b1;

  // Map the 4-bit channel onto a RAM address; out-of-range channels touch nothing
  assign poll_addr     = AW'({{AW{1'b0}}, poll_if.channel});
  assign poll_in_range = 32'(poll_if.channel) < CHANNELS;

  prfs_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv && s1_in_range_q),
    .waddr_i (s1_addr_q),
    .wdata_i (new_entry),
    .re_i    (poll_xfer),
    .raddr_i (poll_addr),
    .rdata_o (ram_rdata)
  );

  // Pick forwarded data over the RAM when the previous update hit this entry;
  // an entry never written reads as its reset value.
  always_comb begin
    if (fwd_hit_q) begin
      cur_entry = fwd_entry_q;
    end else if (s1_entry_vld_q) begin
      cur_entry = prfs_entry_t'(ram_rdata);
    end else begin
      cur_entry = '0;
    end
  end

  assign en_bit  = enable_mask_q[s1_channel_q];
  assign elapsed = s1_now_q - cur_entry.last_time;

  // Fault state update for one poll
  always_comb begin
    new_entry   = cur_entry;
    ev          = EV_NONE;
    log_vld     = 1'b0;
    next_slot_d = next_slot_q;
    if (s1_in_range_q) begin
      priority if (s1_fault_q && !cur_entry.active) begin
        new_entry.active    = 1'b1;
        new_entry.retries   = '0;
        new_entry.last_time = s1_now_q;
        ev                  = EV_DETECTED;
        log_vld             = 1'b1;
        next_slot_d         = (next_slot_q == SLOT_LAST) ? '0 : next_slot_q + 1'b1;
      end else if (!s1_fault_q && cur_entry.active) begin
        if (elapsed > {16'd0, clear_delay_q}) begin
          new_entry.active = 1'b0;
          ev               = EV_CLEARED;
        end
      end else if (cur_entry.active && en_bit) begin
        if (cur_entry.retries < retry_limit_q) begin
          new_entry.retries   = cur_entry.retries + 1'b1;
          new_entry.last_time = s1_now_q;
          ev                  = EV_RETRY;
        end else begin
          new_entry.active = 1'b0;
          ev               = EV_DISABLED;
        end
      end else begin
        // Hold the entry: idle channel, or a fault with no switch to retry
        new_entry = cur_entry;
      end
    end
  end

  // Report only the low bits of the ring slot
  assign slot_ext = {{SLOT_W{1'b0}}, next_slot_q};

  always_comb begin
    entry_vld_d = entry_vld_q;
    if (s1_adv && s1_in_range_q) begin
      entry_vld_d[s1_addr_q] = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_mask_q <= ENABLE_MASK_RST;
      clear_delay_q <= CLEAR_DELAY_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      entry_vld_q   <= '0;
      next_slot_q   <= '0;
      fwd_hit_q     <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          CFG_ENABLE_MASK: enable_mask_q <= cfg_if.data;
          CFG_CLEAR_DELAY: clear_delay_q <= cfg_if.data;
          CFG_RETRY_LIMIT: retry_limit_q <= cfg_if.data[3:0];
          default: ;
        endcase
      end
      if (poll_xfer) begin
        s1_valid_q <= 1'b1;
        // Forward when this cycle's write back lands on the entry just read
        fwd_hit_q  <= s1_adv && s1_in_range_q && (s1_addr_q == poll_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        entry_vld_q <= entry_vld_d;
        next_slot_q <= next_slot_d;
      end else if (res_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (poll_xfer) begin
      s1_channel_q   <= poll_if.channel;
      s1_fault_q     <= poll_if.fault_asserted;
      s1_now_q       <= poll_if.now_ticks;
      s1_in_range_q  <= poll_in_range;
      s1_addr_q      <= poll_addr;
      s1_entry_vld_q <= entry_vld_q[poll_addr];
      fwd_entry_q    <= new_entry;
    end
    if (s1_adv) begin
      out_channel_q <= s1_channel_q;
      out_event_q   <= ev;
      out_retry_q   <= s1_in_range_q ? new_entry.retries : '0;
      out_log_vld_q <= log_vld;
      out_slot_q    <= log_vld ? slot_ext[SLOT_W-1:0] : '0;
    end
  end

  assign res_if.valid        = out_valid_q;
  assign res_if.channel_out  = out_channel_q;
  assign res_if.event_res    = out_event_q;
  assign res_if.retry_number = out_retry_q;
  assign res_if.log_valid    = out_log_vld_q;
  assign res_if.log_slot     = out_slot_q;

endmodule

/* design/prfs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module prfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* design/prfs_checker.sv */
// Port-level assertions for the power rail fault retry supervisor and their bind.
module prfs_checker #(
  parameter int unsigned CHANNELS = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [prfs_pkg::CH_W-1:0]       channel_out,
  input logic [prfs_pkg::EVENT_W-1:0]    event_res,
  input logic [prfs_pkg::RETRY_W-1:0]    retry_number,
  input logic                           log_valid,
  input logic [prfs_pkg::SLOT_W-1:0]     log_slot
);
  import prfs_pkg::*;

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(event_res) && $stable(channel_out))
    else $error("result changed while stalled");

  // A log record comes only with a detection, which restarts the retry count
  a_log_detect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && log_valid |-> event_res == EV_DETECTED && retry_number == '0)
    else $error("log record without detection");

  a_log_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !log_valid |-> log_slot == '0)
    else $error("log slot set without log record");

  // A retry pulse always leaves a nonzero count
  a_retry_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && event_res == EV_RETRY |-> retry_number != '0)
    else $error("retry pulse with zero count");

  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && 32'(channel_out) >= CHANNELS |-> event_res == EV_NONE && retry_number == '0)
    else $error("event on a channel beyond range");

endmodule

bind power_rail_fault_retry_supervisor prfs_checker #(
  .CHANNELS (CHANNELS)
) u_prfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid    (res_if.valid),
  .res_ready    (res_if.ready),
  .channel_out  (res_if.channel_out),
  .event_res    (res_if.event_res),
  .retry_number (res_if.retry_number),
  .log_valid    (res_if.log_valid),
  .log_slot     (res_if.log_slot)
);

/* test/tb.sv */
// Testbench for the power rail fault retry supervisor: directed and random polls, scoreboard.
`timescale 1ns / 1ps

module tb;
  import prfs_pkg::*;

  // Drain margin for the path from poll transfer to the result register.
  localparam int PIPE_LAT      = 2;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int NUM_CHANNELS  = 16;

  // One expected result of a poll.
  typedef struct packed {
    logic [CH_W-1:0]    ch;
    prfs_event_e        ev;
    logic [RETRY_W-1:0] rn;
    logic               lv;
    logic [SLOT_W-1:0]  slot;
  } poll_result_t;

  logic clk;
  logic rst_n;

  prfs_poll_if poll_if ();
  prfs_res_if  res_if ();
  prfs_cfg_if  cfg_if ();

  power_rail_fault_retry_supervisor DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .poll_if(poll_if),
    .res_if (res_if),
    .cfg_if (cfg_if)
  );

  // Supervisor copy: configuration and per-channel state as the block should hold them.
  logic [15:0]        en_mask;
  logic [15:0]        clr_delay;
  logic [3:0]         retry_lim;
  logic               chan_active  [NUM_CHANNELS];
  logic [RETRY_W-1:0] chan_retries [NUM_CHANNELS];
  logic [TICK_W-1:0]  chan_last    [NUM_CHANNELS];
  logic [SLOT_W-1:0]  next_slot;

  poll_result_t expected_results[$];
  int           mismatch_count;

  // Stimulus knobs shared by the test tasks and the ready driver.
  int           send_idle_max;
  int           recv_idle_max;
  bit           hold_off_req;

  // Random stimulus: running tick and the fault line level of each channel.
  logic [TICK_W-1:0] stim_tick;
  logic              stim_line [NUM_CHANNELS];

  // Free-running clock, period 10 ns.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one poll to the supervisor copy and return what the block must report.
  function automatic poll_result_t predict_poll_result(input logic [CH_W-1:0] ch,
                                                      input logic fault,
                                                      input logic [TICK_W-1:0] now);
    poll_result_t      r;
    logic [TICK_W-1:0] elapsed;
    r.ch   = ch;
    r.ev   = EV_NONE;
    r.lv   = 1'b0;
    r.slot = '0;
    if (fault && !chan_active[ch]) begin
      // New fault: report it and take the next log slot of the ring.
      chan_active[ch]  = 1'b1;
      chan_retries[ch] = '0;
      chan_last[ch]    = now;
      r.ev             = EV_DETECTED;
      r.lv             = 1'b1;
      r.slot           = next_slot;
      next_slot        = next_slot + 1'b1;
    end else if (!fault && chan_active[ch]) begin
      // Released line clears only once strictly more than the delay has passed, modulo 2^32.
      elapsed = now - chan_last[ch];
      if (elapsed > {16'd0, clr_delay}) begin
        chan_active[ch] = 1'b0;
        r.ev            = EV_CLEARED;
      end
    end else if (chan_active[ch] && en_mask[ch]) begin
      // Persistent fault on a switchable channel: pulse until the limit, then disable.
      if (chan_retries[ch] < retry_lim) begin
        chan_retries[ch] = chan_retries[ch] + 1'b1;
        chan_last[ch]    = now;
        r.ev             = EV_RETRY;
      end else begin
        chan_active[ch] = 1'b0;
        r.ev            = EV_DISABLED;
      end
    end
    r.rn = chan_retries[ch];
    return r;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Offer one poll, hold it until transferred, then predict its result.
  task automatic poll_channel(input logic [CH_W-1:0] ch, input logic fault,
                              input logic [TICK_W-1:0] now);
    int gap;
    gap = (send_idle_max > 0) ? $urandom_range(0, send_idle_max) : 0;
    if (gap > 0) begin
      poll_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    poll_if.valid          = 1'b1;
    poll_if.channel        = ch;
    poll_if.fault_asserted = fault;
    poll_if.now_ticks      = now;
    @(posedge clk);
    while (!poll_if.ready) @(posedge clk);
    expected_results.push_back(predict_poll_result(ch, fault, now));
    @(negedge clk);
  endtask

  // Drop the poll valid and drain every outstanding result before touching registers.
  task automatic wait_idle();
    poll_if.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_ENABLE_MASK: en_mask   = value;
      CFG_CLEAR_DELAY: clr_delay = value;
      CFG_RETRY_LIMIT: retry_lim = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic configure(input logic [15:0] mask, input logic [15:0] delay,
                           input logic [3:0] limit);
    wait_idle();
    write_reg(CFG_ENABLE_MASK, mask);
    write_reg(CFG_CLEAR_DELAY, delay);
    write_reg(CFG_RETRY_LIMIT, {12'd0, limit});
  endtask

  // Reset configuration: retry ladder, disable, no-switch channel, delay edge, tick wrap.
  task automatic test_reset_defaults();
    // Channel 0 is switchable: detection, five pulses, then disable.
    poll_channel(4'd0, 1'b1, 32'd100);
    for (int t = 101; t <= 105; t++) poll_channel(4'd0, 1'b1, t);
    poll_channel(4'd0, 1'b1, 32'd106);
    // Retry count survives the disable until the next detection.
    poll_channel(4'd0, 1'b0, 32'd107);
    poll_channel(4'd0, 1'b1, 32'd108);
    // Release exactly at the delay does not clear; one tick more does.
    poll_channel(4'd0, 1'b0, 32'd113);
    poll_channel(4'd0, 1'b0, 32'd114);
    // Channel 5 has no enable switch: a persistent fault stays silent.
    poll_channel(4'd5, 1'b1, 32'd200);
    poll_channel(4'd5, 1'b1, 32'd201);
    poll_channel(4'd5, 1'b1, 32'd300);
    // Top channel, fault just below tick wrap, released after the wrap.
    poll_channel(4'd15, 1'b1, 32'hFFFF_FFFE);
    poll_channel(4'd15, 1'b0, 32'h0000_0002);
    poll_channel(4'd15, 1'b0, 32'h0000_0004);
    // Switchable channel 12 retried at the top tick value.
    poll_channel(4'd12, 1'b1, 32'hFFFF_FFFF);
    poll_channel(4'd12, 1'b1, 32'hFFFF_FFFF);
    poll_channel(4'd12, 1'b0, 32'h0000_0000);
    // Inactive channel with no fault.
    poll_channel(4'd3, 1'b0, 32'h5555_AAAA);
    poll_channel(4'd10, 1'b0, 32'hAAAA_5555);
  endtask

  // Register extremes: zero limit and delay, full and empty masks, top limit and delay.
  task automatic test_config_extremes();
    configure(16'hFFFF, 16'd0, 4'd0);
    // Zero limit disables on the first persistent poll.
    poll_channel(4'd15, 1'b1, 32'd1000);
    poll_channel(4'd15, 1'b1, 32'd1001);
    // Zero delay: same tick does not clear, the next one does.
    poll_channel(4'd7, 1'b1, 32'd1000);
    poll_channel(4'd7, 1'b0, 32'd1000);
    poll_channel(4'd7, 1'b0, 32'd1001);

    configure(16'h0000, 16'hFFFF, 4'd15);
    poll_channel(4'd9, 1'b1, 32'd5000);
    poll_channel(4'd9, 1'b1, 32'd5001);
    poll_channel(4'd9, 1'b0, 32'd5000 + 32'h0000_FFFF);
    poll_channel(4'd9, 1'b0, 32'd5000 + 32'h0001_0000);

    configure(16'hFFFF, 16'hFFFF, 4'd15);
    // Fifteen pulses, then disable on the sixteenth persistent poll.
    poll_channel(4'd9, 1'b1, 32'd9000);
    for (int i = 1; i <= 16; i++) poll_channel(4'd9, 1'b1, 32'd9000 + i);
  endtask

  // Random polls shaped into fault episodes on a few busy channels, with some noise.
  task automatic run_random_phase(input int n_items);
    int                sel;
    logic [CH_W-1:0]   ch;
    logic              fault;
    logic [CH_W-1:0]   busy [3];
    for (int k = 0; k < 3; k++) busy[k] = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
    for (int n = 0; n < n_items; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) ch = busy[$urandom_range(0, 2)];
      else          ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
      // Advance the tick: mostly small steps, some near the clear delay, a few jumps.
      sel = $urandom_range(0, 99);
      if (sel < 70)      stim_tick = stim_tick + $urandom_range(0, 3);
      else if (sel < 92) stim_tick = stim_tick + {16'd0, clr_delay} - 1 + $urandom_range(0, 2);
      else               stim_tick = $urandom;
      // Toggle the fault line now and then; occasionally send a stray level.
      sel = $urandom_range(0, 99);
      if (sel < 12) stim_line[ch] = ~stim_line[ch];
      if (sel >= 95) fault = 1'($urandom_range(0, 1));
      else           fault = stim_line[ch];
      poll_channel(ch, fault, stim_tick);
    end
  endtask

  task automatic test_random();
    stim_tick = $urandom;
    for (int c = 0; c < NUM_CHANNELS; c++) stim_line[c] = 1'b0;

    configure(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 12)),
              4'($urandom_range(0, 15)));
    run_random_phase(200);

    // No idling on either side.
    send_idle_max = 0;
    recv_idle_max = 0;
    configure(16'hFFFF, 16'($urandom_range(0, 4)), 4'($urandom_range(1, 6)));
    run_random_phase(150);

    send_idle_max = 5;
    recv_idle_max = 5;
    configure(16'($urandom_range(0, 16'hFFFF)), 16'hFFFF, 4'd15);
    run_random_phase(150);

    // Sender flat out, receiver idling; then the reverse.
    send_idle_max = 0;
    configure(ENABLE_MASK_RST, CLEAR_DELAY_RST, RETRY_LIMIT_RST);
    run_random_phase(150);
    send_idle_max = 5;
    recv_idle_max = 0;
    configure(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 40)),
              4'($urandom_range(0, 15)));
    run_random_phase(150);
    recv_idle_max = 5;
  endtask

  // Receiver holds off for a long stretch while polls keep coming: the block must stall.
  task automatic test_backpressure();
    configure(16'hFFFF, 16'd2, 4'd3);
    send_idle_max = 0;
    hold_off_req  = 1'b1;
    run_random_phase(40);
    send_idle_max = 5;
  endtask

  // Result ready: random stall per result, plus a long hold-off when requested.
  initial begin
    int gap;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      gap = (recv_idle_max > 0) ? $urandom_range(0, recv_idle_max) : 0;
      if (gap > 0) begin
        res_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready = 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  // Check every transferred result against the oldest expectation, field by field.
  always @(posedge clk) begin
    poll_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, channel", 32'(res_if.channel_out), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (res_if.channel_out !== want.ch)
          report_mismatch("channel_out", 32'(res_if.channel_out), 32'(want.ch));
        if (res_if.event_res !== want.ev)
          report_mismatch("event_res", 32'(res_if.event_res), 32'(want.ev));
        if (res_if.retry_number !== want.rn)
          report_mismatch("retry_number", 32'(res_if.retry_number), 32'(want.rn));
        if (res_if.log_valid !== want.lv)
          report_mismatch("log_valid", 32'(res_if.log_valid), 32'(want.lv));
        if (res_if.log_slot !== want.slot)
          report_mismatch("log_slot", 32'(res_if.log_slot), 32'(want.slot));
      end
    end
  end

  // Watchdog: end the run if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    int quiet_cycles;
    if (!rst_n) begin
      quiet_cycles = 0;
    end else if ((poll_if.valid && poll_if.ready) || (res_if.valid && res_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Main sequence: reset once, then the tests in turn, then drain and report.
  initial begin
    poll_if.valid          = 1'b0;
    poll_if.channel        = '0;
    poll_if.fault_asserted = 1'b0;
    poll_if.now_ticks      = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = CFG_ENABLE_MASK;
    cfg_if.data            = '0;
    mismatch_count         = 0;
    send_idle_max          = 5;
    recv_idle_max          = 5;
    hold_off_req           = 1'b0;

    en_mask   = ENABLE_MASK_RST;
    clr_delay = CLEAR_DELAY_RST;
    retry_lim = RETRY_LIMIT_RST;
    next_slot = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_active[c]  = 1'b0;
      chan_retries[c] = '0;
      chan_last[c]    = '0;
    end

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_random();
    test_backpressure();

    wait_idle();
    repeat (PIPE_LAT + 8) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
